// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/hsv2rgb_pkg.sv
// ---------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the hsv to rgb converter.
// ---------------------------------------------------------------------------
package hsv2rgb_pkg;

   // field widths
   localparam int unsigned HUE_W  = 15;
   localparam int unsigned CHAN_W = 8;

   // level divide: floor(y / 15300), with 15300 = 255 * 60
   localparam int unsigned LEVEL_Y_W   = 22;
   localparam int unsigned LEVEL_DIV_W = 14;
   localparam logic [LEVEL_DIV_W-1:0] LEVEL_DIV = 14'd15300;
   // floor(2^22 / 15300); estimate is exact or one low for y < 2^22
   localparam int unsigned RECIP_W     = 9;
   localparam logic [RECIP_W-1:0] RECIP_MUL = 9'd274;
   localparam int unsigned RECIP_SHIFT = 22;

   // 60-degree hue sectors
   typedef enum logic [2:0] {
      SEC_RED_YEL,
      SEC_YEL_GRN,
      SEC_GRN_CYN,
      SEC_CYN_BLU,
      SEC_BLU_MAG,
      SEC_MAG_RED
   } sector_type;

   // stage enables of the level unit
   typedef struct packed {
      logic en_mul;
      logic en_scale;
      logic en_recip;
      logic en_fix;
      logic vld_recip;
   } level_ctrl_type;

endpackage

// File: rtl/hsv2rgb_level.sv
// ---------------------------------------------------------------------------
// hsv2rgb_level
// Four-stage level lane: floor(v * (255*D - s*x) / (255*D)), D = 60 << frac.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv2rgb_level
   import hsv2rgb_pkg::*;
#(
   parameter int unsigned HUE_FRAC_BITS = 6
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  level_ctrl_type                                ctrl,
   input  logic [$clog2((60 << HUE_FRAC_BITS) + 1)-1:0]  lane_x,
   input  logic [CHAN_W-1:0]                             sat,
   input  logic [CHAN_W-1:0]                             bri,
   output logic [CHAN_W-1:0]                             level
);

   localparam int unsigned SPAN   = 60 << HUE_FRAC_BITS;
   localparam int unsigned SPAN_W = $clog2(SPAN + 1);
   localparam int unsigned TOTAL  = 255 * SPAN;
   localparam int unsigned TOT_W  = $clog2(TOTAL + 1);
   localparam int unsigned SX_W   = CHAN_W + SPAN_W;
   localparam int unsigned N_W    = CHAN_W + TOT_W;
   localparam int unsigned RP_W   = LEVEL_Y_W + RECIP_W;

   logic [SX_W-1:0]      sx_ff, sx_in;
   logic [CHAN_W-1:0]    bri_ff;
   logic [TOT_W-1:0]     diff;
   logic [N_W-1:0]       n_prod;
   logic [LEVEL_Y_W-1:0] y_ff, y_in;
   logic [LEVEL_Y_W-1:0] yc_ff;
   logic [RP_W-1:0]      r_prod;
   logic [CHAN_W-1:0]    est_ff, est_in;
   logic [LEVEL_Y_W-1:0] chk;
   logic [LEVEL_Y_W-1:0] rem_raw;
   logic [CHAN_W-1:0]    level_ff, level_in;

   // stage a: s * x
   assign sx_in = SX_W'(sat) * SX_W'(lane_x);

   always_ff @(posedge clock) begin
      if (ctrl.en_mul) begin
         sx_ff  <= sx_in;
         bri_ff <= bri;
      end
   end

   // stage b: v * (255*D - s*x), scaled down by the hue fraction bits
   assign diff   = TOT_W'(TOTAL) - TOT_W'(sx_ff);
   assign n_prod = N_W'(bri_ff) * N_W'(diff);
   assign y_in   = LEVEL_Y_W'(n_prod >> HUE_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (ctrl.en_scale) begin
         y_ff <= y_in;
      end
   end

   // stage c: reciprocal estimate of y / 15300
   assign r_prod = RP_W'(y_ff) * RP_W'(RECIP_MUL);
   assign est_in = r_prod[RECIP_SHIFT +: CHAN_W];

   always_ff @(posedge clock) begin
      if (ctrl.en_recip) begin
         est_ff <= est_in;
         yc_ff  <= y_ff;
      end
   end

   // stage d: one-step correction of the estimate
   assign chk      = LEVEL_Y_W'(est_ff) * LEVEL_Y_W'(LEVEL_DIV);
   assign rem_raw  = yc_ff - chk;
   assign level_in = (rem_raw >= LEVEL_Y_W'(LEVEL_DIV)) ? est_ff + CHAN_W'(1) : est_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en_fix) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

   // estimate is never more than one below the true quotient
   `ASSERT_SAME(a_recip_bound, clock, reset, ctrl.en_fix && ctrl.vld_recip, rem_raw < (LEVEL_Y_W'(LEVEL_DIV) << 1), "reciprocal estimate off by more than one")

endmodule

// File: rtl/hsv_to_rgb_converter_top.sv
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// Pipelined hsv to rgb color converter, one pixel per clock while not stalled.
// ---------------------------------------------------------------------------
// usage
//   req_* carries one hsv color per transfer: hue in degrees with
//   HUE_FRAC_BITS fraction bits (clamped just below 360), saturation and
//   brightness as 8-bit codes where 255 is full scale.
//   rsp_* carries the rgb result of each transfer, in input order.
//   a transfer happens on a rising edge with valid high and stall low.
// stages and throughput
//   six register stages: sector split, s*x product, v scaling, reciprocal
//   estimate, quotient correction, channel select. one transfer per clock
//   sustained while rsp_stall is low, as every stage of the three level
//   lanes takes a new pixel as its last one moves on.
// reset
//   synchronous reset empties every stage; rsp_valid is low afterwards.
// receiver stall
//   a stalled result holds on the rsp ports. earlier stages keep filling
//   their empty slots, so req_stall rises only once all six stages hold data.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_converter_top
   import hsv2rgb_pkg::*;
#(
   parameter int unsigned HUE_FRAC_BITS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [HUE_W-1:0]  req_hue,
   input  logic [CHAN_W-1:0] req_saturation,
   input  logic [CHAN_W-1:0] req_brightness,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAN_W-1:0] rsp_red,
   output logic [CHAN_W-1:0] rsp_green,
   output logic [CHAN_W-1:0] rsp_blue
);

   localparam int unsigned SPAN    = 60 << HUE_FRAC_BITS;
   localparam int unsigned SPAN_W  = $clog2(SPAN + 1);
   localparam int unsigned LIMIT   = (360 << HUE_FRAC_BITS) - 1;
   localparam int unsigned LIMIT_W = $clog2(LIMIT + 1);
   localparam int unsigned HC_W    = (LIMIT_W > HUE_W) ? LIMIT_W : HUE_W;
   localparam int unsigned NSTG    = 6;
   localparam int unsigned LAST    = NSTG - 1;

   logic [NSTG-1:0]   stg_vld_ff;
   logic [NSTG-1:0]   load_en;

   logic [HC_W-1:0]   hue_ext, hue_c, base;
   sector_type        sec_in;
   logic [SPAN_W-1:0] rem_in;

   sector_type        sec_ff [0:LAST-1];
   logic [CHAN_W-1:0] bri_ff [0:LAST-1];
   logic [SPAN_W-1:0] rem_ff;
   logic [CHAN_W-1:0] sat_ff;

   level_ctrl_type    lvl_ctrl;
   logic [SPAN_W-1:0] x_t;
   logic [CHAN_W-1:0] lvl_p, lvl_q, lvl_t;

   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic [CHAN_W-1:0] red_in, green_in, blue_in;

   // per-stage load enables; a stage loads when empty or when it drains
   always_comb begin
      load_en[LAST] = !stg_vld_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         load_en[k] = !stg_vld_ff[k] || load_en[k+1];
      end
   end

   assign req_stall = !load_en[0];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= '0;
      end else begin
         if (load_en[0]) begin
            stg_vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (load_en[k]) begin
               stg_vld_ff[k] <= stg_vld_ff[k-1];
            end
         end
      end
   end

   // stage 0: clamp hue, find sector and remainder
   assign hue_ext = HC_W'(req_hue);
   assign hue_c   = (hue_ext > HC_W'(LIMIT)) ? HC_W'(LIMIT) : hue_ext;

   always_comb begin
      if (hue_c >= HC_W'(5 * SPAN)) begin
         sec_in = SEC_MAG_RED;
         base   = HC_W'(5 * SPAN);
      end else if (hue_c >= HC_W'(4 * SPAN)) begin
         sec_in = SEC_BLU_MAG;
         base   = HC_W'(4 * SPAN);
      end else if (hue_c >= HC_W'(3 * SPAN)) begin
         sec_in = SEC_CYN_BLU;
         base   = HC_W'(3 * SPAN);
      end else if (hue_c >= HC_W'(2 * SPAN)) begin
         sec_in = SEC_GRN_CYN;
         base   = HC_W'(2 * SPAN);
      end else if (hue_c >= HC_W'(SPAN)) begin
         sec_in = SEC_YEL_GRN;
         base   = HC_W'(SPAN);
      end else begin
         sec_in = SEC_RED_YEL;
         base   = '0;
      end
   end

   assign rem_in = SPAN_W'(hue_c - base);

   // stage 0 capture; sector and brightness then ride along the level stages
   always_ff @(posedge clock) begin
      if (load_en[0]) begin
         sec_ff[0] <= sec_in;
         bri_ff[0] <= req_brightness;
         rem_ff    <= rem_in;
         sat_ff    <= req_saturation;
      end
      for (int k = 1; k < LAST; k++) begin
         if (load_en[k]) begin
            sec_ff[k] <= sec_ff[k-1];
            bri_ff[k] <= bri_ff[k-1];
         end
      end
   end

   // level lanes: p uses x = D, q uses x = r, t uses x = D - r
   assign lvl_ctrl.en_mul    = load_en[1];
   assign lvl_ctrl.en_scale  = load_en[2];
   assign lvl_ctrl.en_recip  = load_en[3];
   assign lvl_ctrl.en_fix    = load_en[4];
   assign lvl_ctrl.vld_recip = stg_vld_ff[3];

   assign x_t = SPAN_W'(SPAN) - rem_ff;

   hsv2rgb_level #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_lane_p (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lvl_ctrl),
      .lane_x (SPAN_W'(SPAN)),
      .sat    (sat_ff),
      .bri    (bri_ff[0]),
      .level  (lvl_p)
   );

   hsv2rgb_level #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_lane_q (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lvl_ctrl),
      .lane_x (rem_ff),
      .sat    (sat_ff),
      .bri    (bri_ff[0]),
      .level  (lvl_q)
   );

   hsv2rgb_level #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_lane_t (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lvl_ctrl),
      .lane_x (x_t),
      .sat    (sat_ff),
      .bri    (bri_ff[0]),
      .level  (lvl_t)
   );

   // output stage: sector picks the channel order
   always_comb begin
      case (sec_ff[LAST-1])
         SEC_RED_YEL: begin
            red_in = bri_ff[LAST-1]; green_in = lvl_t; blue_in = lvl_p;
         end
         SEC_YEL_GRN: begin
            red_in = lvl_q; green_in = bri_ff[LAST-1]; blue_in = lvl_p;
         end
         SEC_GRN_CYN: begin
            red_in = lvl_p; green_in = bri_ff[LAST-1]; blue_in = lvl_t;
         end
         SEC_CYN_BLU: begin
            red_in = lvl_p; green_in = lvl_q; blue_in = bri_ff[LAST-1];
         end
         SEC_BLU_MAG: begin
            red_in = lvl_t; green_in = lvl_p; blue_in = bri_ff[LAST-1];
         end
         default: begin
            red_in = bri_ff[LAST-1]; green_in = lvl_p; blue_in = lvl_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_en[LAST]) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = stg_vld_ff[LAST];
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

   // a request transfer always lands in stage 0
   `ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && !req_stall, stg_vld_ff[0], "accepted request not captured")
   // back-pressure reaches the input only when every stage is full
   `ASSERT_SAME(a_stall_full, clock, reset, req_stall, &stg_vld_ff, "input stalled with an empty stage")
   // a drained output with nothing behind it goes empty
   `ASSERT_NEXT(a_drain_empty, clock, reset, stg_vld_ff[LAST] && !rsp_stall && !stg_vld_ff[LAST-1], !stg_vld_ff[LAST], "result repeated after transfer")

endmodule
